/* design/sls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types and codes for the sortable lifo stack: item layouts, operation
// and status codes, and the command/status bundle between control and datapath.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int DataW      = 32;
  localparam int MaxResults = 16;
  localparam int ViewCntW   = $clog2(MaxResults + 1);

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_SORT  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_VIEW  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DataW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0]  data_value;
    logic [1:0]               status;
    logic [4:0]               entry_count;
    logic                     last_item;
  } result_t;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_PUSH,
    STEP_FULL,
    STEP_POP_RD,
    STEP_POP_OUT,
    STEP_EMPTY,
    STEP_CLEAR,
    STEP_OK,
    STEP_VIEW_START,
    STEP_VIEW_OUT,
    STEP_SORT_START,
    STEP_SORT_LOAD,
    STEP_SORT_CMP,
    STEP_SORT_NEXT,
    STEP_SORT_FIN
  } dp_step_t;

  typedef struct packed {
    dp_step_t                 step;
    logic signed [DataW-1:0]  value;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic few;
    logic view_last;
    logic pass_end;
    logic sort_done;
  } dp_status_t;

endpackage

/* design/sls_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sls_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_ctrl
// Controller: decodes accepted items and sequences pop, view and sort walks
// over the stack memory by issuing datapath steps.
// ----------------------------------------------------------------------------
module sls_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sls_pkg::in_item_t   item,
  input  sls_pkg::dp_status_t stat,
  output sls_pkg::dp_cmd_t    cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_VIEW,
    S_SORT_LOAD,
    S_SORT_CMP,
    S_SORT_END
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.step   = sls_pkg::STEP_NONE;
    cmd.value  = item.value;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (item.operation)
            sls_pkg::OP_PUSH: begin
              cmd.step = stat.full ? sls_pkg::STEP_FULL : sls_pkg::STEP_PUSH;
            end
            sls_pkg::OP_POP: begin
              if (stat.empty) begin
                cmd.step = sls_pkg::STEP_EMPTY;
              end else begin
                cmd.step   = sls_pkg::STEP_POP_RD;
                state_next = S_POP;
              end
            end
            sls_pkg::OP_SORT: begin
              if (stat.few) begin
                cmd.step = sls_pkg::STEP_OK;
              end else begin
                cmd.step   = sls_pkg::STEP_SORT_START;
                state_next = S_SORT_LOAD;
              end
            end
            sls_pkg::OP_CLEAR: begin
              cmd.step = sls_pkg::STEP_CLEAR;
            end
            sls_pkg::OP_VIEW: begin
              if (stat.empty) begin
                cmd.step = sls_pkg::STEP_EMPTY;
              end else begin
                cmd.step   = sls_pkg::STEP_VIEW_START;
                state_next = S_VIEW;
              end
            end
            default: begin
              cmd.step = sls_pkg::STEP_OK;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.step   = sls_pkg::STEP_POP_OUT;
        state_next = S_IDLE;
      end
      S_VIEW: begin
        cmd.step = sls_pkg::STEP_VIEW_OUT;
        if (stat.view_last) begin
          state_next = S_IDLE;
        end
      end
      S_SORT_LOAD: begin
        cmd.step   = sls_pkg::STEP_SORT_LOAD;
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd.step = sls_pkg::STEP_SORT_CMP;
        if (stat.pass_end) begin
          state_next = S_SORT_END;
        end
      end
      S_SORT_END: begin
        if (stat.sort_done) begin
          cmd.step   = sls_pkg::STEP_SORT_FIN;
          state_next = S_IDLE;
        end else begin
          cmd.step   = sls_pkg::STEP_SORT_NEXT;
          state_next = S_SORT_LOAD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

/* design/sls_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_datapath
// Datapath: stack memory, fill count, walk indexes, sort carry register and
// the registered result output.
// ----------------------------------------------------------------------------
module sls_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sls_pkg::dp_cmd_t    cmd,
  output sls_pkg::dp_status_t stat,
  output sls_pkg::result_t    result,
  output logic                result_strobe
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int VW = sls_pkg::ViewCntW;
  localparam int DW = sls_pkg::DataW;

  logic [FW-1:0]        fill, fill_next;
  logic [AW-1:0]        idx, lo, top;
  logic [VW-1:0]        view_left, view_init;
  logic signed [DW-1:0] carry, carry_next;
  logic signed [DW-1:0] rdata;
  logic [DW-1:0]        rdata_raw;
  logic                 carry_gt;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [DW-1:0]        wdata;

  logic                 emit;
  sls_pkg::result_t     res_next;

  sls_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata     = $signed(rdata_raw);
  assign top       = AW'(fill - FW'(1));
  assign carry_gt  = carry > rdata;
  assign view_init = (32'(fill) > 32'(sls_pkg::MaxResults)) ?
                     VW'(sls_pkg::MaxResults) : VW'(fill);

  assign stat.empty     = (fill == '0);
  assign stat.full      = (fill == FW'(STACK_DEPTH));
  assign stat.few       = (fill < FW'(2));
  assign stat.view_last = (view_left == VW'(1));
  assign stat.pass_end  = (idx == lo);
  assign stat.sort_done = ((lo + AW'(1)) == top);

  always_comb begin
    we         = 1'b0;
    waddr      = lo;
    wdata      = carry;
    re         = 1'b0;
    raddr      = top;
    fill_next  = fill;
    carry_next = carry;
    emit       = 1'b0;
    res_next.data_value  = '0;
    res_next.status      = sls_pkg::ST_OK;
    res_next.last_item   = 1'b1;
    unique case (cmd.step)
      sls_pkg::STEP_PUSH: begin
        we        = 1'b1;
        waddr     = AW'(fill);
        wdata     = cmd.value;
        fill_next = fill + FW'(1);
        emit      = 1'b1;
      end
      sls_pkg::STEP_FULL: begin
        res_next.status = sls_pkg::ST_FULL;
        emit            = 1'b1;
      end
      sls_pkg::STEP_POP_RD: begin
        re        = 1'b1;
        fill_next = fill - FW'(1);
      end
      sls_pkg::STEP_POP_OUT: begin
        res_next.data_value = rdata;
        emit                = 1'b1;
      end
      sls_pkg::STEP_EMPTY: begin
        res_next.status = sls_pkg::ST_EMPTY;
        emit            = 1'b1;
      end
      sls_pkg::STEP_CLEAR: begin
        fill_next = '0;
        emit      = 1'b1;
      end
      sls_pkg::STEP_OK: begin
        emit = 1'b1;
      end
      sls_pkg::STEP_VIEW_START: begin
        re = 1'b1;
      end
      sls_pkg::STEP_VIEW_OUT: begin
        re                  = !stat.view_last;
        raddr               = idx;
        res_next.data_value = rdata;
        res_next.last_item  = stat.view_last;
        emit                = 1'b1;
      end
      sls_pkg::STEP_SORT_START: begin
        re = 1'b1;
      end
      sls_pkg::STEP_SORT_LOAD: begin
        re         = 1'b1;
        raddr      = idx - AW'(1);
        carry_next = rdata;
      end
      sls_pkg::STEP_SORT_CMP: begin
        // larger value keeps sinking toward the bottom
        we         = 1'b1;
        waddr      = idx + AW'(1);
        wdata      = carry_gt ? rdata : carry;
        carry_next = carry_gt ? carry : rdata;
        re         = !stat.pass_end;
        raddr      = idx - AW'(1);
      end
      sls_pkg::STEP_SORT_NEXT: begin
        we = 1'b1;
        re = 1'b1;
      end
      sls_pkg::STEP_SORT_FIN: begin
        we   = 1'b1;
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    res_next.entry_count = 5'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      result_strobe <= 1'b0;
    end else begin
      fill          <= fill_next;
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    carry <= carry_next;
    if (emit) begin
      result <= res_next;
    end
    unique case (cmd.step)
      sls_pkg::STEP_VIEW_START: begin
        idx       <= top - AW'(1);
        view_left <= view_init;
      end
      sls_pkg::STEP_VIEW_OUT: begin
        idx       <= idx - AW'(1);
        view_left <= view_left - VW'(1);
      end
      sls_pkg::STEP_SORT_START: begin
        idx <= top;
        lo  <= '0;
      end
      sls_pkg::STEP_SORT_LOAD, sls_pkg::STEP_SORT_CMP: begin
        idx <= idx - AW'(1);
      end
      sls_pkg::STEP_SORT_NEXT: begin
        idx <= top;
        lo  <= lo + AW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/sortable_lifo_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sortable_lifo_stack
// Bounded LIFO stack of signed 32-bit values with push, pop, clear, an
// in-place ascending sort (smallest on top) and a top-to-bottom view.
// ----------------------------------------------------------------------------
// channel   ports                    handshake
// item in   start, busy, cmd         taken when start is high and busy is low
// result    result_strobe, result    one cycle per result, cannot be held off
//
// push, clear, sort below two entries, invalid codes and empty pop/view:
// result in the cycle after the item, next item taken in that same cycle.
// pop: one memory read; view: min(entries, 16) results, top first.
// sort: bubble passes over the memory through its single read port; busy
// stays high meanwhile for n >= 2 entries, and stays low below that.
// reset clears the fill count; stack contents are left as they are.
// ----------------------------------------------------------------------------
module sortable_lifo_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sls_pkg::in_item_t cmd,
  output logic              result_strobe,
  output sls_pkg::result_t  result
);

  sls_pkg::dp_cmd_t    dp_cmd;
  sls_pkg::dp_status_t dp_stat;

  sls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (cmd),
    .stat  (dp_stat),
    .cmd   (dp_cmd),
    .busy  (busy)
  );

  sls_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .result        (result),
    .result_strobe (result_strobe)
  );

  a_quick_ops: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.operation != sls_pkg::OP_POP &&
     cmd.operation != sls_pkg::OP_VIEW && cmd.operation != sls_pkg::OP_SORT)
    |=> result_strobe)
    else $error("single-cycle item gave no result");

  a_view_busy: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.last_item) |-> busy)
    else $error("non-final view result while idle");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.status == sls_pkg::ST_FULL)
    |-> (result.entry_count == 5'(STACK_DEPTH)))
    else $error("full status with stack not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.status == sls_pkg::ST_EMPTY)
    |-> (result.entry_count == 5'd0 && result.data_value == '0))
    else $error("empty status with entries or data");

endmodule
